[rtl/assert_macros.svh]
// Assertion macros used by the checker file hns_checker.sv.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, idle during reset.
`define HNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hns: same-cycle check failed");
// Next-cycle implication, idle during reset.
`define HNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hns: next-cycle check failed");
`endif

[rtl/hns_pkg.sv]
// Shared types, codes and constants for the histogram normalize/smooth unit.
// No dependencies.
package hns_pkg;

  localparam int MAX_BINS_DEF  = 512;
  localparam int RAW_WIDTH_DEF = 24;

  localparam int CFG_W      = 10;
  localparam int NUM_BINS_W = 10;
  localparam int LEVEL_W    = 8;
  localparam int QUO_W      = 2 * LEVEL_W;
  localparam int OUT_W      = 16;
  localparam int IDX_W      = 9;
  localparam int IN_RAW_W   = 24;
  localparam int ACC_W      = OUT_W + 2;

  localparam logic [NUM_BINS_W-1:0] NUM_BINS_RST   = 10'd360;
  localparam logic [LEVEL_W-1:0]    OUT_AT_MAX_RST = 8'd0;
  localparam logic [LEVEL_W-1:0]    OUT_AT_MIN_RST = 8'd255;

  // Configuration register indexes
  localparam logic [1:0] REG_NUM_BINS   = 2'd0;
  localparam logic [1:0] REG_OUT_AT_MAX = 2'd1;
  localparam logic [1:0] REG_OUT_AT_MIN = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_UNIFORM   = 2'd1,
    STS_RANGE     = 2'd2,
    STS_NOT_READY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ADDR_SWEEP,
    ADDR_LEFT,
    ADDR_CENTER,
    ADDR_RIGHT
  } addr_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD2
  } acc_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NRM_RD,
    ST_NRM_MUL,
    ST_NRM_DINIT,
    ST_NRM_DIV,
    ST_NRM_WR,
    ST_RD_L,
    ST_RD_C,
    ST_RD_R,
    ST_RD_SUM
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      sweep_init;
    logic      rd_en;
    addr_sel_e addr_sel;
    logic      mul_en;
    logic      div_start;
    logic      nrm_wr;
    logic      finish;
    acc_op_e   acc_op;
    logic      idx_latch;
    logic      out_en;
    logic      out_sum;
    status_e   out_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic normalized;
    logic uniform;
    logic load_full;
    logic idx_ok;
    logic sweep_last;
    logic div_last;
  } sts_t;

endpackage

[rtl/hns_div.sv]
// Bit-serial restoring divider: quotient of (prod << 8) / span, one bit a cycle.
// Depends on hns_pkg.
module hns_div #(
  parameter int RAW_WIDTH = hns_pkg::RAW_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [RAW_WIDTH+hns_pkg::LEVEL_W-1:0] prod_i,
  input  logic [RAW_WIDTH-1:0]                span_i,
  output logic [hns_pkg::QUO_W-1:0]           quo_o,
  output logic                                last_o
);

  localparam int LW = hns_pkg::LEVEL_W;
  localparam int QW = hns_pkg::QUO_W;
  localparam int CNTW = $clog2(QW);

  logic [RAW_WIDTH-1:0] rem_q;
  logic [QW-1:0]        low_q;
  logic [QW-1:0]        quo_q;
  logic [CNTW-1:0]      cnt_q;
  logic                 run_q;

  logic [RAW_WIDTH:0]   trial;
  logic [RAW_WIDTH:0]   diff;
  logic                 ge;

  // One trial subtraction per step
  assign trial = {rem_q, low_q[QW-1]};
  assign ge    = trial >= {1'b0, span_i};
  assign diff  = trial - {1'b0, span_i};

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (last_o) run_q <= 1'b0;
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= prod_i[RAW_WIDTH+LW-1:LW];
      low_q <= {prod_i[LW-1:0], LW'(0)};
    end else if (run_q) begin
      rem_q <= ge ? diff[RAW_WIDTH-1:0] : trial[RAW_WIDTH-1:0];
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign last_o = run_q && (cnt_q == CNTW'(QW - 1));
  assign quo_o  = quo_q;

endmodule

[rtl/hns_datapath.sv]
// Datapath: configuration, bin memory, min/max tracking, mapping and smoothing.
// Depends on hns_pkg and hns_div.
module hns_datapath #(
  parameter int MAX_BINS  = hns_pkg::MAX_BINS_DEF,
  parameter int RAW_WIDTH = hns_pkg::RAW_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hns_pkg::cmd_t                  cmd_i,
  output hns_pkg::sts_t                  sts_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [hns_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [hns_pkg::IN_RAW_W-1:0]   raw_value_i,
  input  logic [hns_pkg::IDX_W-1:0]      bin_index_i,
  output logic                           result_valid_o,
  output logic [hns_pkg::OUT_W-1:0]      smoothed_value_o,
  output logic [1:0]                     status_o
);

  localparam int AW  = $clog2(MAX_BINS);
  localparam int CW  = $clog2(MAX_BINS + 1);
  localparam int NW  = (CW > hns_pkg::NUM_BINS_W) ? CW : hns_pkg::NUM_BINS_W;
  localparam int IW  = (CW > hns_pkg::IDX_W) ? CW : hns_pkg::IDX_W;
  localparam int SW  = (RAW_WIDTH > hns_pkg::OUT_W) ? RAW_WIDTH : hns_pkg::OUT_W;
  localparam int LW  = hns_pkg::LEVEL_W;
  localparam int PW  = RAW_WIDTH + LW;
  localparam int OW  = hns_pkg::OUT_W;
  localparam int ACW = hns_pkg::ACC_W;

  // Configuration registers
  logic [hns_pkg::NUM_BINS_W-1:0] num_bins_q;
  logic [LW-1:0]                  out_at_max_q;
  logic [LW-1:0]                  out_at_min_q;

  // Histogram state
  logic [CW-1:0]        ptr_q, ptr_d, ptr_eff;
  logic [RAW_WIDTH-1:0] min_q, min_d, min_eff;
  logic [RAW_WIDTH-1:0] max_q, max_d, max_eff;
  logic                 flag_q;
  logic [CW-1:0]        ring_q;
  logic [CW-1:0]        sweep_q;
  logic [AW-1:0]        idx_q;

  // Work registers
  logic [SW-1:0]        rd_data_q;
  logic [PW-1:0]        prod_q;
  logic [ACW-1:0]       acc_q;
  logic                 result_valid_q;
  logic [OW-1:0]        value_q;
  logic [1:0]           status_q;

  logic [SW-1:0] mem [MAX_BINS];

  logic [NW-1:0]        n_full;
  logic [CW-1:0]        n_c;
  logic [RAW_WIDTH-1:0] raw_w;
  logic                 load_ok;
  logic [CW-1:0]        idx_c, left_c, right_c, idx_inc;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;
  logic [SW-1:0]        wr_data;
  logic [RAW_WIDTH-1:0] off, span;
  logic                 dir_up;
  logic [LW-1:0]        delta;
  logic [OW-1:0]        base, nrm_val;
  logic [hns_pkg::QUO_W-1:0] quo;
  logic                 div_last;
  logic [OW-1:0]        rd16;
  logic [ACW-1:0]       sum;

  // Ring size in use: zero counts as one, saturated at MAX_BINS
  always_comb begin
    if (num_bins_q == '0) begin
      n_full = NW'(1);
    end else if (NW'(num_bins_q) > NW'(MAX_BINS)) begin
      n_full = NW'(MAX_BINS);
    end else begin
      n_full = NW'(num_bins_q);
    end
  end
  assign n_c = n_full[CW-1:0];

  // Load: a load after a compute starts a new histogram
  assign raw_w   = RAW_WIDTH'(raw_value_i);
  assign ptr_eff = flag_q ? '0 : ptr_q;
  assign min_eff = flag_q ? '1 : min_q;
  assign max_eff = flag_q ? '0 : max_q;
  assign load_ok = ptr_eff < n_c;

  always_comb begin
    ptr_d = ptr_q;
    min_d = min_q;
    max_d = max_q;
    if (cmd_i.load) begin
      ptr_d = ptr_eff;
      min_d = min_eff;
      max_d = max_eff;
      if (load_ok) begin
        ptr_d = ptr_eff + CW'(1);
        if (raw_w < min_eff) min_d = raw_w;
        if (raw_w > max_eff) max_d = raw_w;
      end
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q     <= hns_pkg::NUM_BINS_RST;
      out_at_max_q   <= hns_pkg::OUT_AT_MAX_RST;
      out_at_min_q   <= hns_pkg::OUT_AT_MIN_RST;
      ptr_q          <= '0;
      min_q          <= '1;
      max_q          <= '0;
      flag_q         <= 1'b0;
      ring_q         <= '0;
      sweep_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          hns_pkg::REG_NUM_BINS:   num_bins_q   <= cfg_wdata_i[hns_pkg::NUM_BINS_W-1:0];
          hns_pkg::REG_OUT_AT_MAX: out_at_max_q <= cfg_wdata_i[LW-1:0];
          hns_pkg::REG_OUT_AT_MIN: out_at_min_q <= cfg_wdata_i[LW-1:0];
          default: ;
        endcase
      end
      ptr_q <= ptr_d;
      min_q <= min_d;
      max_q <= max_d;
      if (cmd_i.load) begin
        flag_q <= 1'b0;
        ring_q <= '0;
      end
      if (cmd_i.sweep_init) sweep_q <= '0;
      else if (cmd_i.nrm_wr) sweep_q <= sweep_q + CW'(1);
      if (cmd_i.finish) begin
        flag_q <= 1'b1;
        ring_q <= n_c;
      end
      result_valid_q <= cmd_i.out_en;
    end
  end

  // Neighbor addresses around the ring
  assign idx_c   = CW'(idx_q);
  assign idx_inc = idx_c + CW'(1);
  assign left_c  = (idx_c == '0) ? ring_q - CW'(1) : idx_c - CW'(1);
  assign right_c = (idx_inc >= ring_q) ? '0 : idx_inc;

  always_comb begin
    unique case (cmd_i.addr_sel)
      hns_pkg::ADDR_SWEEP:  rd_addr = sweep_q[AW-1:0];
      hns_pkg::ADDR_LEFT:   rd_addr = left_c[AW-1:0];
      hns_pkg::ADDR_CENTER: rd_addr = idx_q;
      hns_pkg::ADDR_RIGHT:  rd_addr = right_c[AW-1:0];
      default:              rd_addr = sweep_q[AW-1:0];
    endcase
  end

  // Linear map of one bin
  assign dir_up = out_at_max_q >= out_at_min_q;
  assign delta  = dir_up ? out_at_max_q - out_at_min_q : out_at_min_q - out_at_max_q;
  assign span   = max_q - min_q;
  assign off    = rd_data_q[RAW_WIDTH-1:0] - min_q;
  assign base   = {out_at_min_q, LW'(0)};

  always_comb begin
    if (sts_o.uniform) nrm_val = base;
    else if (dir_up)   nrm_val = base + OW'(quo);
    else               nrm_val = base - OW'(quo);
  end

  // Bin memory, one write and one registered read port
  assign wr_en   = (cmd_i.load && load_ok) || cmd_i.nrm_wr;
  assign wr_addr = cmd_i.nrm_wr ? sweep_q[AW-1:0] : ptr_eff[AW-1:0];
  assign wr_data = cmd_i.nrm_wr ? SW'(nrm_val) : SW'(raw_w);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= mem[rd_addr];
  end

  // Product and smoothing accumulator
  assign rd16 = rd_data_q[OW-1:0];
  assign sum  = acc_q + ACW'(rd16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= PW'(off) * PW'(delta);
    if (cmd_i.idx_latch) idx_q <= AW'(IW'(bin_index_i));
    unique case (cmd_i.acc_op)
      hns_pkg::ACC_LOAD: acc_q <= ACW'(rd16);
      hns_pkg::ACC_ADD2: acc_q <= acc_q + {1'b0, rd16, 1'b0};
      default: ;
    endcase
    if (cmd_i.out_en) begin
      value_q  <= cmd_i.out_sum ? sum[ACW-1:2] : '0;
      status_q <= cmd_i.out_status;
    end
  end

  hns_div #(
    .RAW_WIDTH(RAW_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .prod_i (prod_q),
    .span_i (span),
    .quo_o  (quo),
    .last_o (div_last)
  );

  // Status toward the controller
  assign sts_o.normalized = flag_q;
  assign sts_o.uniform    = min_q == max_q;
  assign sts_o.load_full  = ptr_q >= n_c;
  assign sts_o.idx_ok     = IW'(bin_index_i) < IW'(ring_q);
  assign sts_o.sweep_last = sweep_q == n_c - CW'(1);
  assign sts_o.div_last   = div_last;

  assign result_valid_o   = result_valid_q;
  assign smoothed_value_o = value_q;
  assign status_o         = status_q;

endmodule

[rtl/hns_ctrl.sv]
// Controller state machine: sequences loads, the normalize sweep and reads.
// Depends on hns_pkg.
module hns_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [1:0]    operation_i,
  input  hns_pkg::sts_t sts_i,
  output hns_pkg::cmd_t cmd_o,
  output logic          busy
);

  hns_pkg::state_e state_q, state_d;
  hns_pkg::op_e    op;
  logic            accept;

  assign op     = hns_pkg::op_e'(operation_i);
  assign busy   = state_q != hns_pkg::ST_IDLE;
  assign accept = start && !busy;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hns_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hns_pkg::ST_IDLE: begin
        if (accept && op == hns_pkg::OP_COMPUTE && !sts_i.normalized && sts_i.load_full) begin
          state_d = sts_i.uniform ? hns_pkg::ST_NRM_WR : hns_pkg::ST_NRM_RD;
        end else if (accept && op == hns_pkg::OP_READ && sts_i.normalized && sts_i.idx_ok) begin
          state_d = hns_pkg::ST_RD_L;
        end
      end
      hns_pkg::ST_NRM_RD:    state_d = hns_pkg::ST_NRM_MUL;
      hns_pkg::ST_NRM_MUL:   state_d = hns_pkg::ST_NRM_DINIT;
      hns_pkg::ST_NRM_DINIT: state_d = hns_pkg::ST_NRM_DIV;
      hns_pkg::ST_NRM_DIV:   if (sts_i.div_last) state_d = hns_pkg::ST_NRM_WR;
      hns_pkg::ST_NRM_WR: begin
        if (sts_i.sweep_last) state_d = hns_pkg::ST_IDLE;
        else if (sts_i.uniform) state_d = hns_pkg::ST_NRM_WR;
        else state_d = hns_pkg::ST_NRM_RD;
      end
      hns_pkg::ST_RD_L:   state_d = hns_pkg::ST_RD_C;
      hns_pkg::ST_RD_C:   state_d = hns_pkg::ST_RD_R;
      hns_pkg::ST_RD_R:   state_d = hns_pkg::ST_RD_SUM;
      hns_pkg::ST_RD_SUM: state_d = hns_pkg::ST_IDLE;
      default:            state_d = hns_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      hns_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            hns_pkg::OP_LOAD: cmd_o.load = 1'b1;
            hns_pkg::OP_COMPUTE: begin
              if (sts_i.normalized) begin
                cmd_o.out_en     = 1'b1;
                cmd_o.out_status = sts_i.uniform ? hns_pkg::STS_UNIFORM : hns_pkg::STS_OK;
              end else if (!sts_i.load_full) begin
                cmd_o.out_en     = 1'b1;
                cmd_o.out_status = hns_pkg::STS_NOT_READY;
              end else begin
                cmd_o.sweep_init = 1'b1;
              end
            end
            hns_pkg::OP_READ: begin
              if (!sts_i.normalized) begin
                cmd_o.out_en     = 1'b1;
                cmd_o.out_status = hns_pkg::STS_NOT_READY;
              end else if (!sts_i.idx_ok) begin
                cmd_o.out_en     = 1'b1;
                cmd_o.out_status = hns_pkg::STS_RANGE;
              end else begin
                cmd_o.idx_latch = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      hns_pkg::ST_NRM_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = hns_pkg::ADDR_SWEEP;
      end
      hns_pkg::ST_NRM_MUL:   cmd_o.mul_en = 1'b1;
      hns_pkg::ST_NRM_DINIT: cmd_o.div_start = 1'b1;
      hns_pkg::ST_NRM_DIV:   ;
      hns_pkg::ST_NRM_WR: begin
        cmd_o.nrm_wr = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.finish     = 1'b1;
          cmd_o.out_en     = 1'b1;
          cmd_o.out_status = sts_i.uniform ? hns_pkg::STS_UNIFORM : hns_pkg::STS_OK;
        end
      end
      hns_pkg::ST_RD_L: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = hns_pkg::ADDR_LEFT;
      end
      hns_pkg::ST_RD_C: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = hns_pkg::ADDR_CENTER;
        cmd_o.acc_op   = hns_pkg::ACC_LOAD;
      end
      hns_pkg::ST_RD_R: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = hns_pkg::ADDR_RIGHT;
        cmd_o.acc_op   = hns_pkg::ACC_ADD2;
      end
      hns_pkg::ST_RD_SUM: begin
        cmd_o.out_en     = 1'b1;
        cmd_o.out_sum    = 1'b1;
        cmd_o.out_status = hns_pkg::STS_OK;
      end
      default: ;
    endcase
  end

endmodule

[rtl/histogram_normalize_smooth_unit.sv]
// Top level of the histogram min-max normalize and circular smoothing unit.
// Depends on hns_pkg, hns_ctrl, hns_datapath (and hns_div below it).
//
//   Channel   Handshake                 Payload
//   command   start in, busy out        operation_i, raw_value_i, bin_index_i
//   result    result_valid_o strobe     smoothed_value_o, status_o
//   config    cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Load and no-op items leave busy low, so the unit takes one item per cycle.
// A read steps through three reads of the bin memory's read port and a sum.
// A compute that normalizes steps through the n bins one by one (read, multiply,
// 16-step serial divider, write back), or only writes back each bin if uniform.
// Every other compute and a failing read answer in the next cycle.
// Results appear in the cycle after the work ends, for one cycle; reset is async.
module histogram_normalize_smooth_unit #(
  parameter int MAX_BINS  = hns_pkg::MAX_BINS_DEF,
  parameter int RAW_WIDTH = hns_pkg::RAW_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [hns_pkg::IN_RAW_W-1:0]  raw_value_i,
  input  logic [hns_pkg::IDX_W-1:0]     bin_index_i,
  output logic                          result_valid_o,
  output logic [hns_pkg::OUT_W-1:0]     smoothed_value_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [hns_pkg::CFG_W-1:0]     cfg_wdata_i
);

  hns_pkg::cmd_t cmd;
  hns_pkg::sts_t sts;

  hns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .operation_i(operation_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  hns_datapath #(
    .MAX_BINS (MAX_BINS),
    .RAW_WIDTH(RAW_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .raw_value_i     (raw_value_i),
    .bin_index_i     (bin_index_i),
    .result_valid_o  (result_valid_o),
    .smoothed_value_o(smoothed_value_o),
    .status_o        (status_o)
  );

endmodule

[rtl/hns_checker.sv]
// Port-level checks for histogram_normalize_smooth_unit, attached by bind.
// Depends on hns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hns_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                operation_i,
  input logic                      result_valid_o,
  input logic [hns_pkg::OUT_W-1:0] smoothed_value_o,
  input logic [1:0]                status_o
);

  logic item_acc;
  logic short_op;
  logic long_op;
  logic bad_sts;

  // Accepted item and its kind
  assign item_acc = start && !busy;
  assign short_op = operation_i == hns_pkg::OP_LOAD || operation_i == hns_pkg::OP_NOP;
  assign long_op  = operation_i == hns_pkg::OP_COMPUTE || operation_i == hns_pkg::OP_READ;
  assign bad_sts  = result_valid_o && status_o != hns_pkg::STS_OK;

  // A result only shows once the unit is free again
  `HNS_ASSERT_IMP(a_result_when_idle, result_valid_o, !busy)

  // Results whose status is not OK carry a zero value
  `HNS_ASSERT_IMP(a_zero_on_status, bad_sts, smoothed_value_o == '0)

  // Loads and no-ops finish at once and give no result
  `HNS_ASSERT_NXT(a_load_nop_quiet, item_acc && short_op, !busy && !result_valid_o)

  // Compute and read items either answer next cycle or keep the unit busy
  `HNS_ASSERT_NXT(a_cmp_rd_progress, item_acc && long_op, busy || result_valid_o)

endmodule

bind histogram_normalize_smooth_unit hns_checker u_hns_checker (.*);

[tb/testbench.sv]
// Testbench for histogram_normalize_smooth_unit: directed and random command items,
// results checked against an in-bench predictor of normalization and smoothing.
// Depends on hns_pkg and the RTL of the unit.
module testbench;

  localparam int N_ITEMS   = 1650;
  localparam int WD_LIMIT  = 200000;
  localparam int BIN_DEPTH = 512;
  localparam int BIG_ITEMS = 600;

  typedef struct {
    hns_pkg::op_e op;
    logic [23:0]  raw;
    logic [8:0]   idx;
  } cmd_item_t;

  typedef struct {
    logic [15:0]      value;
    hns_pkg::status_e sts;
  } bin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation_i = 2'd0;
  logic [23:0] raw_value_i = '0;
  logic [8:0] bin_index_i = '0;
  logic result_valid_o;
  logic [15:0] smoothed_value_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [hns_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  cmd_item_t   pending_items[$];
  bin_result_t expected_bins[$];
  int errors = 0;
  int pushed = 0;
  int accepted = 0;
  int idle_pct = 19;
  int quiet_cycles = 0;

  // Predictor state
  int unsigned p_num_bins = 360, p_out_max = 0, p_out_min = 255;
  int unsigned p_store[BIN_DEPTH];
  int unsigned p_load_ptr = 0, p_min = 24'hFFFFFF, p_max = 0, p_ring = 0;
  bit p_norm = 0;

  histogram_normalize_smooth_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .raw_value_i, .bin_index_i,
    .result_valid_o, .smoothed_value_o, .status_o, .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned ring_size();
    if (p_num_bins == 0) return 1;
    if (p_num_bins > BIN_DEPTH) return BIN_DEPTH;
    return p_num_bins;
  endfunction

  task automatic new_histogram();
    p_load_ptr = 0;
    p_min = 24'hFFFFFF;
    p_max = 0;
    p_norm = 0;
    p_ring = 0;
  endtask

  // Linear map of one raw bin onto the output levels, Q8.8 truncated
  function automatic int unsigned map_level(int unsigned v);
    longint unsigned span, off, q;
    span = longint'(p_max) - longint'(p_min);
    off  = longint'(v - p_min);
    if (p_out_max >= p_out_min) begin
      q = ((off * (p_out_max - p_out_min)) << 8) / span;
      return (p_out_min << 8) + int'(q);
    end
    q = ((off * (p_out_min - p_out_max)) << 8) / span;
    return (p_out_min << 8) - int'(q);
  endfunction

  // Work out the result (if any) of one accepted item
  task automatic predict_bins(logic [1:0] op, logic [23:0] raw, logic [8:0] idx);
    int unsigned n, lft, rgt, sum;
    bit uni;
    bin_result_t r;
    n = ring_size();
    r.value = '0;
    case (hns_pkg::op_e'(op))
      hns_pkg::OP_LOAD: begin
        if (p_norm) new_histogram();
        if (p_load_ptr < n) begin
          p_store[p_load_ptr] = raw;
          p_load_ptr++;
          if (raw < p_min) p_min = raw;
          if (raw > p_max) p_max = raw;
        end
      end
      hns_pkg::OP_COMPUTE: begin
        uni = (p_min == p_max);
        if (p_norm) r.sts = uni ? hns_pkg::STS_UNIFORM : hns_pkg::STS_OK;
        else if (p_load_ptr < n) r.sts = hns_pkg::STS_NOT_READY;
        else begin
          for (int i = 0; i < n; i++)
            p_store[i] = uni ? (p_out_min << 8) : map_level(p_store[i]);
          p_ring = n;
          p_norm = 1;
          r.sts = uni ? hns_pkg::STS_UNIFORM : hns_pkg::STS_OK;
        end
        expected_bins.push_back(r);
      end
      hns_pkg::OP_READ: begin
        if (!p_norm || p_ring == 0) r.sts = hns_pkg::STS_NOT_READY;
        else if (idx >= p_ring) r.sts = hns_pkg::STS_RANGE;
        else begin
          lft = (idx == 0) ? p_ring - 1 : idx - 1;
          rgt = (idx + 1 >= p_ring) ? 0 : idx + 1;
          sum = p_store[lft] + 2 * p_store[idx] + p_store[rgt];
          r.value = (sum >> 2) & 16'hFFFF;
          r.sts = hns_pkg::STS_OK;
        end
        expected_bins.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (item %0d)", what, got, want, accepted);
    errors++;
  endtask

  // Command driver
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_item_t it;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_bins(operation_i, raw_value_i, bin_index_i);
        accepted++;
        if (accepted > 2 * N_ITEMS / 3) idle_pct = 0;
        else if (accepted > N_ITEMS / 3) idle_pct = 86;
      end
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          it = pending_items.pop_front();
          operation_i <= it.op;
          raw_value_i <= it.raw;
          bin_index_i <= it.idx;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    bin_result_t w;
    if (rst_ni && result_valid_o) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected result status", status_o, -1);
      end else begin
        w = expected_bins.pop_front();
        if (status_o !== w.sts) report_mismatch("status", status_o, w.sts);
        if (smoothed_value_o !== w.value) report_mismatch("value", smoothed_value_o, w.value);
      end
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || start || busy || expected_bins.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, int unsigned data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data[hns_pkg::CFG_W-1:0];
    if (index == hns_pkg::REG_NUM_BINS) p_num_bins = data & 10'h3FF;
    else if (index == hns_pkg::REG_OUT_AT_MAX) p_out_max = data & 8'hFF;
    else if (index == hns_pkg::REG_OUT_AT_MIN) p_out_min = data & 8'hFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(hns_pkg::op_e op, int unsigned raw, int unsigned idx);
    cmd_item_t it;
    it.op = op;
    it.raw = raw[23:0];
    it.idx = idx[8:0];
    pending_items.push_back(it);
    pushed++;
  endtask

  function automatic int unsigned pick_level();
    if ($urandom_range(99) < 30) return $urandom_range(1) ? 255 : 0;
    return $urandom_range(255);
  endfunction

  initial begin
    int unsigned nb, n, nloads, mode, base, width, val, nreads, big_left;
    big_left = 4;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: not computed yet, unused op, ignored register index
    push_item(hns_pkg::OP_READ, 0, 0);
    push_item(hns_pkg::OP_COMPUTE, 0, 0);
    push_item(hns_pkg::OP_NOP, 24'hFFFFFF, 9'h1FF);
    wait_idle();
    write_reg(2'd3, 10'h3FF);
    write_reg(hns_pkg::REG_NUM_BINS, 4);
    write_reg(hns_pkg::REG_OUT_AT_MAX, 255);
    write_reg(hns_pkg::REG_OUT_AT_MIN, 0);
    // Extreme raw values, a load into a full store, compute twice, range errors
    push_item(hns_pkg::OP_LOAD, 0, 0);
    push_item(hns_pkg::OP_LOAD, 24'hFFFFFF, 0);
    push_item(hns_pkg::OP_COMPUTE, 0, 0);
    push_item(hns_pkg::OP_LOAD, 24'h123456, 0);
    push_item(hns_pkg::OP_LOAD, 7, 0);
    push_item(hns_pkg::OP_LOAD, 99, 0);
    push_item(hns_pkg::OP_COMPUTE, 0, 0);
    push_item(hns_pkg::OP_COMPUTE, 0, 0);
    push_item(hns_pkg::OP_READ, 0, 0);
    push_item(hns_pkg::OP_READ, 0, 3);
    push_item(hns_pkg::OP_READ, 0, 4);
    push_item(hns_pkg::OP_READ, 0, 511);
    wait_idle();
    // Uniform histogram with equal levels
    write_reg(hns_pkg::REG_NUM_BINS, 3);
    write_reg(hns_pkg::REG_OUT_AT_MAX, 200);
    write_reg(hns_pkg::REG_OUT_AT_MIN, 200);
    repeat (3) push_item(hns_pkg::OP_LOAD, 5, 0);
    push_item(hns_pkg::OP_COMPUTE, 0, 0);
    push_item(hns_pkg::OP_COMPUTE, 0, 0);
    push_item(hns_pkg::OP_READ, 0, 1);
    wait_idle();
    // Falling map, ring size lowered after loading
    write_reg(hns_pkg::REG_NUM_BINS, 5);
    write_reg(hns_pkg::REG_OUT_AT_MAX, 0);
    write_reg(hns_pkg::REG_OUT_AT_MIN, 255);
    for (int i = 0; i < 5; i++) push_item(hns_pkg::OP_LOAD, $urandom, 0);
    wait_idle();
    write_reg(hns_pkg::REG_NUM_BINS, 3);
    push_item(hns_pkg::OP_COMPUTE, 0, 0);
    push_item(hns_pkg::OP_READ, 0, 0);
    push_item(hns_pkg::OP_READ, 0, 2);
    push_item(hns_pkg::OP_READ, 0, 3);

    // Random histograms, mostly small rings
    while (pushed < N_ITEMS) begin
      wait_idle();
      val = $urandom_range(99);
      if (val < 3 && big_left > 0 && pushed + BIG_ITEMS < N_ITEMS) begin
        big_left--;
        nb = (big_left == 0) ? 1023 : ((big_left == 1) ? 600 : 512);
      end else if (val < 10) nb = $urandom_range(2);
      else nb = $urandom_range(3, 24);
      write_reg(hns_pkg::REG_NUM_BINS, nb);
      write_reg(hns_pkg::REG_OUT_AT_MAX, pick_level());
      write_reg(hns_pkg::REG_OUT_AT_MIN, pick_level());
      n = ring_size();
      if ($urandom_range(99) < 8) push_item(hns_pkg::OP_READ, $urandom, $urandom);
      nloads = n;
      val = $urandom_range(99);
      if (val < 5 && n > 1) nloads = n - 1;
      else if (val < 10) nloads = n + 2;
      mode = $urandom_range(3);
      base = $urandom;
      width = $urandom_range(1, 300);
      for (int i = 0; i < nloads; i++) begin
        case (mode)
          0: val = $urandom;
          1: val = (base & 24'hFFFFFF) + $urandom_range(width - 1);
          2: val = base;
          default: val = $urandom_range(1) ? 24'hFFFFFF : $urandom_range(3);
        endcase
        if ($urandom_range(99) < 4) push_item(hns_pkg::OP_NOP, $urandom, $urandom);
        push_item(hns_pkg::OP_LOAD, val, $urandom);
      end
      push_item(hns_pkg::OP_COMPUTE, $urandom, $urandom);
      if ($urandom_range(99) < 10) push_item(hns_pkg::OP_COMPUTE, $urandom, $urandom);
      nreads = $urandom_range(1, 8);
      for (int i = 0; i < nreads; i++) begin
        if ($urandom_range(99) < 85) begin
          push_item(hns_pkg::OP_READ, $urandom, $urandom_range(n - 1));
        end else begin
          push_item(hns_pkg::OP_READ, $urandom, $urandom_range(511));
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
